// ===== rtl/ds_twr_distance_assert.svh =====
// Assertion macros used by ds_twr_distance.sv
`ifndef DS_TWR_DISTANCE_ASSERT_SVH
`define DS_TWR_DISTANCE_ASSERT_SVH

// antecedent implies consequent in the same cycle, off during reset
`define DSTWR_ASSERT_IMPLY(label, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// condition holds at every edge, off during reset
`define DSTWR_ASSERT_ALWAYS(label, rst, c) \
  label: assert property (@(posedge clk) disable iff (rst) (c)) \
    else $error("assertion failed");

`endif

// ===== rtl/dstwr_pkg.sv =====
`default_nettype none
package dstwr_pkg;
  // distance scale in Q0.24
  localparam logic [22:0] SCALE_Q24   = 23'd7871474;
  localparam int          SCALE_SHIFT = 24;
  localparam logic [14:0] MAX_DIST_CM = 15'd1000;
  localparam int          NUM_BITS    = 64;
  localparam int          Q_BITS      = 16;

  // control riding along each divider cell
  typedef struct packed {
    logic valid;
    logic neg;   // numerator negative
    logic dz;    // divisor zero
  } dstwr_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/dstwr_div_cell.sv =====
`default_nettype none
// One restoring-division step: one quotient bit per cell
module dstwr_div_cell
  import dstwr_pkg::*;
#(
  parameter int DW = 42
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire dstwr_ctl_t          ctl_in,
  input  wire logic [DW-1:0]       rem_in,
  input  wire logic [NUM_BITS-1:0] dvd_in,
  input  wire logic [DW-1:0]       den_in,
  input  wire logic [Q_BITS-1:0]   q_in,
  output dstwr_ctl_t               ctl_out,
  output logic      [DW-1:0]       rem_out,
  output logic      [NUM_BITS-1:0] dvd_out,
  output logic      [DW-1:0]       den_out,
  output logic      [Q_BITS-1:0]   q_out
);
  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        qbit;

  // shift in next dividend bit, try subtract
  always_comb begin
    trial = {rem_in, dvd_in[NUM_BITS-1]};
    diff  = trial - {1'b0, den_in};
    qbit  = (trial >= {1'b0, den_in});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
    if (en) begin
      rem_out <= qbit ? diff[DW-1:0] : trial[DW-1:0];
      dvd_out <= {dvd_in[NUM_BITS-2:0], 1'b0};
      den_out <= den_in;
      q_out   <= {q_in[Q_BITS-2:0], qbit};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ds_twr_distance.sv =====
// Pipeline: 6 arithmetic stages and 64 divider cells lie between request accept and result.
// Throughput: one request per cycle unless stalled; the 64-cell divider chain sets the latency.
// The whole pipeline holds while a result waits and m_tready is low.
// Reset: synchronous active-high rst clears all valid bits; data registers are not reset.
`default_nettype none
module ds_twr_distance
  import dstwr_pkg::*;
#(
  parameter int STAMP_BITS = 40
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // poll_tx, poll_rx, resp_tx, resp_rx, final_tx, final_rx (STAMP_BITS each), zero fill
  input  wire logic [((6*STAMP_BITS+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // distance_cm [9:0], range_error [10], zero fill
  output logic [15:0] m_tdata
);
  localparam int SB = STAMP_BITS;
  localparam int DW = SB + 2;
  localparam int LO = SB / 2;
  localparam int HI = SB - LO;
  localparam int NC = NUM_BITS;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: intervals and differences
  logic                 v1;
  logic [SB-1:0]        round1, reply1, round2, reply2;
  logic signed [SB:0]   d1, d2;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_tvalid;
    if (adv) begin
      round1 <= s_tdata[4*SB-1:3*SB] - s_tdata[SB-1:0];
      reply1 <= s_tdata[3*SB-1:2*SB] - s_tdata[2*SB-1:SB];
      round2 <= s_tdata[6*SB-1:5*SB] - s_tdata[3*SB-1:2*SB];
      reply2 <= s_tdata[5*SB-1:4*SB] - s_tdata[4*SB-1:3*SB];
    end
  end
  assign d1 = $signed({1'b0, round1}) - $signed({1'b0, reply1});
  assign d2 = $signed({1'b0, round2}) - $signed({1'b0, reply2});

  // stage 2: partial products, num = d1*reply2 + d2*round1
  logic                      v2;
  logic signed [SB+LO+1:0]   p0, p2;
  logic signed [SB+HI+1:0]   p1, p3;
  logic [DW-1:0]             den2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      p0   <= d1 * $signed({1'b0, reply2[LO-1:0]});
      p1   <= d1 * $signed({1'b0, reply2[SB-1:LO]});
      p2   <= d2 * $signed({1'b0, round1[LO-1:0]});
      p3   <= d2 * $signed({1'b0, round1[SB-1:LO]});
      den2 <= DW'(round1) + DW'(round2) + DW'(reply1) + DW'(reply2);
    end
  end

  // stage 3: 64-bit wrapped sum
  logic          v3;
  logic [NC-1:0] num3;
  logic [DW-1:0] den3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      num3 <= NC'(p0) + (NC'(p1) << LO) + NC'(p2) + (NC'(p3) << LO);
      den3 <= den2;
    end
  end

  // stage 4: sign and magnitude into the divider
  dstwr_ctl_t    ctl [NC+1];
  logic [DW-1:0] rem [NC+1];
  logic [NC-1:0] dvd [NC+1];
  logic [DW-1:0] den [NC+1];
  logic [Q_BITS-1:0] qv [NC+1];
  always_ff @(posedge clk) begin
    if (rst) ctl[0] <= '0;
    else if (adv) ctl[0] <= '{valid: v3, neg: num3[NC-1], dz: (den3 == '0)};
    if (adv) begin
      dvd[0] <= num3[NC-1] ? (NC'(0) - num3) : num3;
      den[0] <= den3;
    end
  end
  assign rem[0] = '0;
  assign qv[0]  = '0;

  // divider chain
  for (genvar i = 0; i < NC; i++) begin : g_cell
    dstwr_div_cell #(.DW(DW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .ctl_in(ctl[i]), .rem_in(rem[i]), .dvd_in(dvd[i]), .den_in(den[i]), .q_in(qv[i]),
      .ctl_out(ctl[i+1]), .rem_out(rem[i+1]), .dvd_out(dvd[i+1]), .den_out(den[i+1]),
      .q_out(qv[i+1])
    );
  end

  // stage 5: wrap to signed 16 bits and scale
  logic [Q_BITS-1:0] t16, tmag;
  logic              v5, tneg5, dz5;
  logic [38:0]       prod5;
  assign t16  = ctl[NC].neg ? (Q_BITS'(0) - qv[NC]) : qv[NC];
  assign tmag = t16[Q_BITS-1] ? (Q_BITS'(0) - t16) : t16;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= ctl[NC].valid;
    if (adv) begin
      prod5 <= 39'(tmag) * 39'(SCALE_Q24);
      tneg5 <= t16[Q_BITS-1];
      dz5   <= ctl[NC].dz;
    end
  end

  // stage 6: range check into output register
  logic [14:0] scaled;
  logic        err;
  assign scaled = prod5[SCALE_SHIFT+14:SCALE_SHIFT];
  assign err    = dz5 || (tneg5 && scaled != '0) || (!tneg5 && scaled > MAX_DIST_CM);
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= v5;
    if (adv) begin
      m_tdata <= {5'd0, err, err ? 10'd0 : scaled[9:0]};
    end
  end

`include "ds_twr_distance_assert.svh"
  `DSTWR_ASSERT_IMPLY(a_err_zero, rst, m_tvalid && m_tdata[10], m_tdata[9:0] == 10'd0)
  `DSTWR_ASSERT_IMPLY(a_dist_max, rst, m_tvalid, m_tdata[9:0] <= 10'd1000)
  `DSTWR_ASSERT_ALWAYS(a_ready, rst, s_tready == (!m_tvalid || m_tready))
endmodule
`default_nettype wire

// ===== verif/ds_twr_distance_tb.sv =====
`default_nettype none
module ds_twr_distance_tb
  import dstwr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = 40;
  localparam int DW = ((6*SB+7)/8)*8;
  localparam int LATENCY = 70;
  localparam int STALL_LIMIT = 4000;
  localparam logic [SB-1:0] SMAX = {SB{1'b1}};

  typedef struct packed {
    logic       range_error;
    logic [9:0] distance_cm;
  } range_t;

  // ranging math for one exchange
  function automatic range_t compute_range(logic [DW-1:0] d);
    logic [SB-1:0] p_tx, p_rx, r_tx, r_rx, f_tx, f_rx;
    logic [63:0] round1, reply1, round2, reply2, d1, d2, num, den, mag, q, tmag, scaled;
    logic [15:0] t;
    range_t r;
    p_tx = d[0*SB +: SB]; p_rx = d[1*SB +: SB]; r_tx = d[2*SB +: SB];
    r_rx = d[3*SB +: SB]; f_tx = d[4*SB +: SB]; f_rx = d[5*SB +: SB];
    round1 = 64'(SB'(r_rx - p_tx));
    reply1 = 64'(SB'(r_tx - p_rx));
    round2 = 64'(SB'(f_rx - r_tx));
    reply2 = 64'(SB'(f_tx - r_rx));
    d1 = round1 - reply1;
    d2 = round2 - reply2;
    num = d1 * reply2 + d2 * reply1 + d2 * d1;
    den = round1 + round2 + reply1 + reply2;
    r = '0;
    if (den == 0) begin
      r.range_error = 1'b1;
    end else begin
      mag = num[63] ? -num : num;
      q = mag / den;
      if (num[63]) q = -q;
      t = q[15:0];
      tmag = t[15] ? 64'(17'h10000 - t) : 64'(t);
      scaled = (tmag * 64'(SCALE_Q24)) >> SCALE_SHIFT;
      if (t[15]) begin
        if (scaled != 0) r.range_error = 1'b1;
      end else if (scaled > 64'(MAX_DIST_CM)) begin
        r.range_error = 1'b1;
      end else begin
        r.distance_cm = scaled[9:0];
      end
    end
    return r;
  endfunction

  class range_scoreboard;
    range_t pending[$];
    int errors = 0;

    function void note_request(logic [DW-1:0] d);
      pending.push_back(compute_range(d));
    endfunction

    function void check_result(logic [15:0] data);
      range_t exp_r;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", data);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (data[9:0] !== exp_r.distance_cm) begin
        $error("distance_cm expected %0d actual %0d", exp_r.distance_cm, data[9:0]);
        errors++;
      end
      if (data[10] !== exp_r.range_error) begin
        $error("range_error expected %0d actual %0d", exp_r.range_error, data[10]);
        errors++;
      end
      if (data[15:11] !== 5'b0) begin
        $error("zero fill expected 0 actual %h", data[15:11]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;

  range_scoreboard sb = new();
  logic [DW-1:0] stamp_sets[$];
  bit sending_done = 1'b0;
  bit no_gaps = 1'b0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  ds_twr_distance #(.STAMP_BITS(SB)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [SB-1:0] rand_stamp();
    return SB'({$urandom(), $urandom()});
  endfunction

  function automatic logic [DW-1:0] pack_set(logic [SB-1:0] a, b, c, e, f, g);
    return {g, f, e, c, b, a};
  endfunction

  // realistic exchange: reply times up to 200000 ticks or up to 2^32, propagation of 0 to 2200 ticks or -300 to 0
  function automatic logic [DW-1:0] realistic_set();
    logic [SB-1:0] t0, tof, rep1, rep2;
    tof = SB'($urandom_range(0, 2200));
    if ($urandom_range(0, 5) == 0) tof = SB'(-$signed(64'($urandom_range(0, 300))));
    rep1 = $urandom_range(0, 1) ? SB'($urandom_range(0, 200000)) : rand_stamp() >> 8;
    rep2 = $urandom_range(0, 1) ? SB'($urandom_range(0, 200000)) : rand_stamp() >> 8;
    t0 = rand_stamp();
    return pack_set(t0, '0, '0, '0, '0, '0) | make_chain(t0, tof, rep1, rep2);
  endfunction

  function automatic logic [DW-1:0] make_chain(logic [SB-1:0] t0, tof, rep1, rep2);
    logic [SB-1:0] b0, p_rx, r_tx, r_rx, f_tx, f_rx;
    b0 = rand_stamp();
    p_rx = b0;
    r_tx = b0 + rep1;
    r_rx = t0 + tof + rep1 + tof;
    f_tx = r_rx + rep2;
    f_rx = r_tx + tof + rep2 + tof;
    return pack_set('0, p_rx, r_tx, r_rx, f_tx, f_rx);
  endfunction

  // drive requests at the falling edge
  task automatic send_sets();
    logic [DW-1:0] d;
    int gap;
    while (stamp_sets.size() != 0) begin
      d = stamp_sets.pop_front();
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= d;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      sb.note_request(d);
      @(negedge clk);
    end
    s_tvalid <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int wait_cycles;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, zero divisor, negative, too far, wide bits
    stamp_sets.push_back('0);
    stamp_sets.push_back({6{SMAX}});
    stamp_sets.push_back(pack_set(SMAX, '0, SMAX, '0, SMAX, '0));
    stamp_sets.push_back(pack_set('0, SMAX, '0, SMAX, '0, SMAX));
    stamp_sets.push_back(pack_set(SB'(5), SB'(5), SB'(5), SB'(5), SB'(5), SB'(5)));
    stamp_sets.push_back(make_chain('0, '0, SB'(1000), SB'(1000)));
    stamp_sets.push_back(make_chain('0, SB'(1), SB'(1000), SB'(1000)));
    stamp_sets.push_back(make_chain('0, SB'(2131), SB'(1000), SB'(1000)));
    stamp_sets.push_back(make_chain('0, SB'(2132), SB'(1000), SB'(1000)));
    stamp_sets.push_back(make_chain('0, SB'(2135), SB'(1000), SB'(1000)));
    stamp_sets.push_back(make_chain('0, SB'(60000), SB'(1000), SB'(1000)));
    stamp_sets.push_back(make_chain('0, SB'(-64'sd1), SB'(1000), SB'(1000)));
    stamp_sets.push_back(make_chain('0, SB'(-64'sd50), SB'(1000), SB'(1000)));
    stamp_sets.push_back(make_chain(SMAX - SB'(10), SB'(700), SB'(5000), SB'(300)));
    stamp_sets.push_back(make_chain('0, SB'(300), SMAX >> 1, SB'(7)));
    stamp_sets.push_back(make_chain('0, SB'(1500), SB'(3), SMAX));
    stamp_sets.push_back(pack_set('0, SB'(1), '0, SB'(1), '0, '0));
    stamp_sets.push_back(pack_set(SB'(7), '0, '0, '0, '0, SB'(7)));
    no_gaps = 1'b1;
    send_sets();
    no_gaps = 1'b0;

    // random: mostly realistic exchanges, some raw noise
    for (int n = 0; n < 1000; n++) begin
      if ($urandom_range(0, 3) == 0)
        stamp_sets.push_back(pack_set(rand_stamp(), rand_stamp(), rand_stamp(),
                                      rand_stamp(), rand_stamp(), rand_stamp()));
      else
        stamp_sets.push_back(realistic_set());
      if (n == 300) begin
        send_sets();
        hold_off = 1'b1;
        no_gaps = 1'b1;
      end
      if (n == 550) begin
        send_sets();
        no_gaps = 1'b0;
      end
    end
    send_sets();

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/dstwr_pkg.sv
rtl/dstwr_div_cell.sv
rtl/ds_twr_distance.sv
verif/ds_twr_distance_tb.sv
